// ===== design/sovl_pkg.sv =====
// Package with the shared constants, codes and types of the sphere overlap insert checker.
`default_nettype none
package sovl_pkg;

  localparam int LIST_DEPTH = 1024;
  localparam int COORD_BITS = 24;

  localparam int ADDR_BITS  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS + 1;
  localparam int RS2_W      = 2 * COORD_BITS;
  localparam int SUM_W      = SQ_W + 2;
  localparam int COUNT_W    = 11;

  localparam logic CMD_TRY   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } fsm_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [RAD_BITS-1:0]   r;
  } entry_t;

endpackage
`default_nettype wire

// ===== design/sphere_overlap_insert_check_top.sv =====
// Top level of the sphere overlap insert checker: placed-sphere memory, scan pipeline and control.
`default_nettype none
// The block keeps a list of placed spheres in one synchronous memory, one word per sphere
// holding the centre and the radius. A try transaction is checked against every placed
// sphere: the memory is read at one entry per cycle and a four-stage pipeline (read, centre
// differences and radius sum, squares, sum and compare) decides whether the squared centre
// distance is at most the squared radius sum. Touching counts as an overlap. The first hit
// ends the scan and rejects the candidate; a candidate that hits nothing is written to the
// next free entry and placed. The scan walks the placed entries through the pipeline and then
// hands the result over to the output register; a try on an empty list still passes through
// the scan state, while a clear transaction, or a try on a full list, skips the scan. One
// transaction is worked on at a time: in_stall is high from acceptance until the result has
// moved into the output register. That register lets the next transaction be accepted while
// the previous result still waits on out_stall, but the next result then waits for the
// register to empty before it is handed over.
// The memory needs no clearing after reset, since only entries below the fill count are read.
module sphere_overlap_insert_check_top
  import sovl_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic signed [COORD_BITS-1:0] in_cand_x,
  input  wire logic signed [COORD_BITS-1:0] in_cand_y,
  input  wire logic signed [COORD_BITS-1:0] in_cand_z,
  input  wire logic        [RAD_BITS-1:0]   in_cand_radius,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [1:0]            out_status,
  output logic             [COUNT_W-1:0]    out_list_count
);

  // Control state.
  fsm_t                state_r, state_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CNT_BITS-1:0] issue_idx_r, issue_idx_nxt;
  status_t             status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                v1_r, v2_r, v3_r;

  // Candidate held for the whole scan.
  logic signed [COORD_BITS-1:0] cand_x_r, cand_y_r, cand_z_r;
  logic        [RAD_BITS-1:0]   cand_r_r;

  // Placed-sphere memory with a registered read port.
  entry_t placed_mem_r [LIST_DEPTH];
  entry_t rd_data_r;
  entry_t wr_data;
  logic   mem_we;
  logic   rd_en;

  // Pipeline payload.
  logic signed [DIFF_W-1:0]   dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0]   dx_nxt, dy_nxt, dz_nxt;
  logic        [COORD_BITS-1:0] rs_r, rs_nxt;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic        [SQ_W-1:0]     sqx_r, sqy_r, sqz_r;
  logic        [RS2_W-1:0]    rs2_r;
  logic        [SUM_W-1:0]    dist2;

  logic [COUNT_W-1:0] out_count_r;
  status_t            out_status_r;

  logic accept;
  logic issuing;
  logic hit;
  logic drain;
  logic scan_done;
  logic out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign issuing = (state_r == S_SCAN) && (issue_idx_r != count_r);

  // Stage 1: centre differences and radius sum from the word just read.
  assign dx_nxt = DIFF_W'(cand_x_r) - DIFF_W'($signed(rd_data_r.x));
  assign dy_nxt = DIFF_W'(cand_y_r) - DIFF_W'($signed(rd_data_r.y));
  assign dz_nxt = DIFF_W'(cand_z_r) - DIFF_W'($signed(rd_data_r.z));
  assign rs_nxt = COORD_BITS'(cand_r_r) + COORD_BITS'(rd_data_r.r);

  // Stage 2: squares; each result is non-negative and fits SQ_W bits.
  assign px = (2*DIFF_W)'(dx_r) * (2*DIFF_W)'(dx_r);
  assign py = (2*DIFF_W)'(dy_r) * (2*DIFF_W)'(dy_r);
  assign pz = (2*DIFF_W)'(dz_r) * (2*DIFF_W)'(dz_r);

  // Stage 3: the exact distance sum is wide enough that no saturation is needed.
  assign dist2 = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
  assign hit   = v3_r && (dist2 <= SUM_W'(rs2_r));
  assign drain = !issuing && !v1_r && !v2_r && !v3_r;
  assign scan_done = (state_r == S_SCAN) && (hit || drain);

  assign wr_data = '{x: cand_x_r, y: cand_y_r, z: cand_z_r, r: cand_r_r};

  // Next state, counters and the handover into the output register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          issue_idx_nxt = '0;
          if (in_cmd == CMD_CLEAR) begin
            status_nxt = ST_CLEARED;
            state_nxt  = S_FIN;
          end else if (count_r == CNT_BITS'(LIST_DEPTH)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          status_nxt = hit ? ST_OVERLAP : ST_PLACED;
          state_nxt  = S_FIN;
        end else if (issuing) begin
          rd_en         = 1'b1;
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (status_r)
            ST_PLACED: begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
            ST_CLEARED: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_idx_r <= '0;
      status_r    <= ST_PLACED;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_idx_r <= issue_idx_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      // A finished scan flushes whatever reads are still in flight.
      v1_r        <= rd_en;
      v2_r        <= v1_r && !scan_done;
      v3_r        <= v2_r && !scan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cand_x_r <= in_cand_x;
      cand_y_r <= in_cand_y;
      cand_z_r <= in_cand_z;
      cand_r_r <= in_cand_radius;
    end
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
    rs_r  <= rs_nxt;
    sqx_r <= px[SQ_W-1:0];
    sqy_r <= py[SQ_W-1:0];
    sqz_r <= pz[SQ_W-1:0];
    rs2_r <= RS2_W'(rs_r) * RS2_W'(rs_r);
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  // Reads and writes never fall in the same cycle: writes happen only after a scan ends.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      placed_mem_r[count_r[ADDR_BITS-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= placed_mem_r[issue_idx_r[ADDR_BITS-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_list_count = out_count_r;

endmodule
`default_nettype wire

// ===== design/sovl_chk.sv =====
// Port-level checker for the sphere overlap insert checker, with its bind statement.
`default_nettype none
module sovl_chk
  import sovl_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic [COUNT_W-1:0] out_list_count
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_list_count))
    else $error("stalled result changed");

  // One transaction at a time: the input closes right after an acceptance.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // A clear always reports an empty list.
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CLEARED |-> out_list_count == '0)
    else $error("clear result with nonzero count");

  // A full rejection reports the list depth.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_list_count == COUNT_W'(LIST_DEPTH))
    else $error("full result with wrong count");

endmodule

bind sphere_overlap_insert_check_top sovl_chk u_sovl_chk (.*);
`default_nettype wire
